// ===== rtl/core/heap_sorter_core_defines.svh =====
// Assertion macros shared by the heap sorter RTL.
`ifndef HEAP_SORTER_CORE_DEFINES_SVH
`define HEAP_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hs_pkg.sv =====
// Package with the word types, sizes and ordering function of the heap sorter.
package hs_pkg;

  localparam int HS_MAX_ITEMS = 64;
  localparam int HS_DATA_W    = 32;

  typedef struct packed {
    logic signed [HS_DATA_W-1:0] value;
    logic                        last;
  } hs_in_t;

  typedef struct packed {
    logic signed [HS_DATA_W-1:0] sorted_value;
    logic                        final_res;
  } hs_out_t;

  function automatic logic hs_gt(input logic signed [HS_DATA_W-1:0] a,
                                 input logic signed [HS_DATA_W-1:0] b);
    return a > b;
  endfunction

endpackage

// ===== rtl/core/heap_sorter_core.sv =====
// Heapsort engine: stores signed words, sorts them in place and emits them in ascending order.
//
// Words are loaded one per cycle while busy is low; words beyond MAX_ITEMS are dropped.
// The word marked last raises busy and starts an in-place heapsort in a two-read, one-write
// memory, driven by one shared comparator: each level of a sift-down steps through a child
// read, a child compare and a compare with the sifted word, and each sift adds setup states
// that load the sifted word and pass on to the next sift. The sorted words then leave
// one per cycle after a registered read, each with out_valid high for exactly one
// cycle and final_res set on the last one; the receiver cannot stall them. busy falls in the
// cycle after the final word.
`include "heap_sorter_core_defines.svh"

module heap_sorter_core
  import hs_pkg::*;
#(
  parameter int MAX_ITEMS = HS_MAX_ITEMS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  hs_in_t  in_word,
  output logic    out_valid,
  output hs_out_t out_word
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = AW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LOAD    = 9'b000000010,
    S_LOAD_W  = 9'b000000100,
    S_CHILD   = 9'b000001000,
    S_CMP1    = 9'b000010000,
    S_CMP2    = 9'b000100000,
    S_NEXT    = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_EMIT    = 9'b100000000
  } hs_state_t;

  hs_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] child_idx_r, child_idx_nxt;
  logic [AW-1:0] emit_idx_r, emit_idx_nxt;
  logic          build_r, build_nxt;
  logic          right_ok_r, right_ok_nxt;
  logic signed [HS_DATA_W-1:0] cur_r, cur_nxt;
  logic signed [HS_DATA_W-1:0] child_val_r, child_val_nxt;

  logic signed [HS_DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [HS_DATA_W-1:0] rdata_a_r, rdata_b_r;
  logic                        mem_we, rd_en;
  logic [AW-1:0]               waddr, raddr_a, raddr_b;
  logic signed [HS_DATA_W-1:0] wdata;

  logic signed [HS_DATA_W-1:0] op_x, op_y;
  logic                        gt;
  logic [XW-1:0]               left_x, right_x, len_x;
  logic [CW-1:0]               n_cur;
  logic [AW-1:0]               root;
  logic                        emit_last;

  assign gt        = hs_gt(op_x, op_y);
  assign left_x    = XW'({pos_r, 1'b1});
  assign right_x   = left_x + XW'(1);
  assign len_x     = XW'(len_r);
  assign root      = AW'(k_r - CW'(1));
  assign emit_last = (CW'(emit_idx_r) + CW'(1)) == n_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    end_nxt       = end_r;
    pos_nxt       = pos_r;
    child_idx_nxt = child_idx_r;
    emit_idx_nxt  = emit_idx_r;
    build_nxt     = build_r;
    right_ok_nxt  = right_ok_r;
    cur_nxt       = cur_r;
    child_val_nxt = child_val_r;
    mem_we        = 1'b0;
    waddr         = '0;
    wdata         = '0;
    rd_en         = 1'b0;
    raddr_a       = '0;
    raddr_b       = '0;
    op_x          = '0;
    op_y          = '0;
    n_cur         = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count_r < MAX_C) begin
            mem_we = 1'b1;
            waddr  = count_r[AW-1:0];
            wdata  = in_word.value;
            n_cur  = count_r + CW'(1);
          end
          count_nxt = n_cur;
          if (in_word.last) begin
            count_nxt = '0;
            n_nxt     = n_cur;
            if (n_cur >= CW'(2)) begin
              build_nxt = 1'b1;
              k_nxt     = n_cur >> 1;
              state_nxt = S_LOAD;
            end else if (n_cur == CW'(1)) begin
              emit_idx_nxt = '0;
              state_nxt    = S_EMIT_RD;
            end
          end
        end
      end
      S_LOAD: begin
        rd_en     = 1'b1;
        raddr_a   = build_r ? root : '0;
        raddr_b   = end_r;
        pos_nxt   = build_r ? root : '0;
        len_nxt   = build_r ? n_r : CW'(end_r);
        state_nxt = S_LOAD_W;
      end
      S_LOAD_W: begin
        if (build_r) begin
          cur_nxt = rdata_a_r;
        end else begin
          cur_nxt = rdata_b_r;
          mem_we  = 1'b1;
          waddr   = end_r;
          wdata   = rdata_a_r;
        end
        state_nxt = S_CHILD;
      end
      S_CHILD: begin
        if (left_x >= len_x) begin
          mem_we    = 1'b1;
          waddr     = pos_r;
          wdata     = cur_r;
          state_nxt = S_NEXT;
        end else begin
          rd_en        = 1'b1;
          raddr_a      = left_x[AW-1:0];
          raddr_b      = right_x[AW-1:0];
          right_ok_nxt = right_x < len_x;
          state_nxt    = S_CMP1;
        end
      end
      S_CMP1: begin
        op_x = rdata_b_r;
        op_y = rdata_a_r;
        if (right_ok_r && gt) begin
          child_val_nxt = rdata_b_r;
          child_idx_nxt = right_x[AW-1:0];
        end else begin
          child_val_nxt = rdata_a_r;
          child_idx_nxt = left_x[AW-1:0];
        end
        state_nxt = S_CMP2;
      end
      S_CMP2: begin
        op_x   = child_val_r;
        op_y   = cur_r;
        mem_we = 1'b1;
        waddr  = pos_r;
        if (gt) begin
          wdata     = child_val_r;
          pos_nxt   = child_idx_r;
          state_nxt = S_CHILD;
        end else begin
          wdata     = cur_r;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (build_r) begin
          if (k_r == CW'(1)) begin
            build_nxt = 1'b0;
            end_nxt   = AW'(n_r - CW'(1));
          end else begin
            k_nxt = k_r - CW'(1);
          end
          state_nxt = S_LOAD;
        end else if (end_r == AW'(1)) begin
          emit_idx_nxt = '0;
          state_nxt    = S_EMIT_RD;
        end else begin
          end_nxt   = end_r - AW'(1);
          state_nxt = S_LOAD;
        end
      end
      S_EMIT_RD: begin
        rd_en     = 1'b1;
        raddr_a   = emit_idx_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        rd_en        = 1'b1;
        raddr_a      = emit_idx_r + AW'(1);
        emit_idx_nxt = emit_idx_r + AW'(1);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      build_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      build_r <= build_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    len_r       <= len_nxt;
    end_r       <= end_nxt;
    pos_r       <= pos_nxt;
    child_idx_r <= child_idx_nxt;
    emit_idx_r  <= emit_idx_nxt;
    right_ok_r  <= right_ok_nxt;
    cur_r       <= cur_nxt;
    child_val_r <= child_val_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_EMIT);
  assign out_word.sorted_value = rdata_a_r;
  assign out_word.final_res    = (state_r == S_EMIT) && emit_last;

  `HSC_ASSERT_NOW(a_out_while_busy, clk, rst_n, out_valid, busy, "result word while idle")
  `HSC_ASSERT_NEXT(a_final_frees, clk, rst_n, out_valid && out_word.final_res, !busy,
                   "block still busy after the final word")
  `HSC_ASSERT_NEXT(a_last_starts, clk, rst_n, start && !busy && in_word.last, busy,
                   "last word did not start the sort")
  `HSC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= MAX_C,
                  "fill count beyond capacity")

endmodule
